@@ design/hlot_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hlot_pkg
// Types, constants and the threshold function of the hot-loop trigger table.
// ----------------------------------------------------------------------------
package hlot_pkg;

   localparam int PROGRAMS     = 8;
   localparam int LOOP_OFFSETS = 1024;
   localparam int TABLE_DEPTH  = PROGRAMS * LOOP_OFFSETS;
   localparam int ADDR_W       = $clog2(TABLE_DEPTH);

   // epoch tags: all-ones marks an entry that belongs to no epoch
   localparam int EPOCH_W = 8;
   localparam logic [EPOCH_W-1:0] TAG_NONE   = {EPOCH_W{1'b1}};
   localparam logic [EPOCH_W-1:0] EPOCH_LAST = TAG_NONE - 1'b1;

   localparam logic [31:0] BASE_RESET     = 32'd1000;
   localparam logic [15:0] SPAN_FREE      = 16'd16;
   localparam logic [15:0] SPAN_RAMP      = 16'd64;
   localparam int          DISC_SHIFT     = 8;   // divide by 256
   localparam int          CAP_SHIFT      = 2;   // divide by 4
   localparam logic [3:0]  REASON_NONE    = 4'd0;
   localparam logic [3:0]  REASON_CODEGEN = 4'd7;

   typedef enum logic [2:0] {
      CMD_BACK_EDGE     = 3'd0,
      CMD_MARK_COMPILED = 3'd1,
      CMD_MARK_FAILED   = 3'd2,
      CMD_QUERY         = 3'd3,
      CMD_CLEAR_ALL     = 3'd4
   } cmd_type;

   typedef enum logic {
      CLR_SWEEP = 1'b0,
      CLR_RUN   = 1'b1
   } clr_state_type;

   typedef struct packed {
      logic [2:0]  command;
      logic [2:0]  program_id;
      logic [9:0]  jump_back_offset;
      logic [15:0] loop_span;
      logic [3:0]  failure_reason;
      logic [7:0]  failing_opcode;
   } req_type;

   typedef struct packed {
      logic        start_compile;
      logic        entry_present;
      logic [31:0] iteration_count;
      logic [31:0] effective_threshold;
      logic        attempted_flag;
      logic        compiled_flag;
      logic        failed_flag;
      logic [3:0]  stored_reason;
      logic [7:0]  stored_opcode;
   } rsp_type;

   typedef struct packed {
      logic [EPOCH_W-1:0] tag;
      logic [31:0]        threshold;
      logic [31:0]        count;
      logic [7:0]         opcode;
      logic [3:0]         reason;
      logic               failed;
      logic               compiled;
      logic               attempted;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef struct packed {
      logic          we;
      entry_type     wr_entry;
      rsp_type       rsp;
   } upd_out_type;

   typedef struct packed {
      logic               busy;
      logic               last_epoch;
      logic [EPOCH_W-1:0] epoch;
      logic [ADDR_W-1:0]  sweep_addr;
   } clr_stat_type;

   function automatic logic [31:0] span_threshold(input logic [31:0] base,
                                                  input logic [15:0] span);
      logic [15:0] extra;
      logic [37:0] prod;
      logic [31:0] cap;
      logic [31:0] disc;
      extra = span - SPAN_FREE;
      cap   = base >> CAP_SHIFT;
      prod  = 38'(extra[5:0]) * 38'(base);
      disc  = 32'(prod >> DISC_SHIFT);
      if (disc > cap || extra >= SPAN_RAMP) begin
         disc = cap;
      end
      if (span <= SPAN_FREE || base == 32'd0) begin
         disc = 32'd0;
      end
      return base - disc;
   endfunction

endpackage

@@ design/hlot_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hlot_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module hlot_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/hlot_clr.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hlot_clr
// Epoch counter for clear-all and the clearing sweep of the entry tags.
// ----------------------------------------------------------------------------
module hlot_clr (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  clear_go,
   output hlot_pkg::clr_stat_type stat
);
   import hlot_pkg::*;

   clr_state_type      state_ff, state_in;
   logic [EPOCH_W-1:0] epoch_ff, epoch_in;
   logic [ADDR_W-1:0]  sweep_addr_ff, sweep_addr_in;
   logic               sweep_done;

   assign sweep_done = (sweep_addr_ff == ADDR_W'(TABLE_DEPTH - 1));

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         CLR_SWEEP: begin
            if (sweep_done) begin
               state_in = CLR_RUN;
            end
         end
         CLR_RUN: begin
            if (clear_go && epoch_ff == EPOCH_LAST) begin
               state_in = CLR_SWEEP;
            end
         end
         default: state_in = CLR_SWEEP;
      endcase
   end

   always_comb begin
      stat.busy       = (state_ff == CLR_SWEEP);
      stat.last_epoch = (epoch_ff == EPOCH_LAST);
      stat.epoch      = epoch_ff;
      stat.sweep_addr = sweep_addr_ff;
   end

   always_comb begin
      epoch_in      = epoch_ff;
      sweep_addr_in = sweep_addr_ff;
      if (state_ff == CLR_SWEEP) begin
         sweep_addr_in = sweep_addr_ff + 1'b1;
      end else begin
         sweep_addr_in = '0;
      end
      if (clear_go) begin
         epoch_in = (epoch_ff == EPOCH_LAST) ? '0 : epoch_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= CLR_SWEEP;
         epoch_ff      <= '0;
         sweep_addr_ff <= '0;
      end else begin
         state_ff      <= state_in;
         epoch_ff      <= epoch_in;
         sweep_addr_ff <= sweep_addr_in;
      end
   end

endmodule

@@ design/hlot_upd.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hlot_upd
// Entry update: first touch, back-edge count, status marks and the result.
// ----------------------------------------------------------------------------
module hlot_upd (
   input  hlot_pkg::req_type            item,
   input  logic                         addr_ok,
   input  logic [31:0]                  first_thr,
   input  hlot_pkg::entry_type          stored,
   input  logic [hlot_pkg::EPOCH_W-1:0] epoch,
   output hlot_pkg::upd_out_type        upd
);
   import hlot_pkg::*;

   logic      hit;
   entry_type cur;
   entry_type nxt;
   logic      start;
   logic      we;
   logic      present;
   logic [31:0] cnt;

   assign hit = addr_ok && (stored.tag == epoch);

   always_comb begin
      cur = stored;
      if (!hit) begin
         cur           = '0;
         cur.tag       = epoch;
         cur.threshold = first_thr;
      end
      nxt   = cur;
      start = 1'b0;
      we    = 1'b0;
      cnt   = cur.count;
      case (item.command)
         CMD_BACK_EDGE: begin
            we = addr_ok;
            if (!cur.attempted && !cur.failed) begin
               if (cur.count != 32'hFFFF_FFFF) begin
                  cnt = cur.count + 32'd1;
               end
               nxt.count = cnt;
               if (cnt == cur.threshold) begin
                  nxt.attempted = 1'b1;
                  start         = 1'b1;
               end
            end
         end
         CMD_MARK_COMPILED: begin
            we           = addr_ok;
            nxt.compiled = 1'b1;
         end
         CMD_MARK_FAILED: begin
            we         = addr_ok;
            nxt.failed = 1'b1;
            if (cur.reason == REASON_NONE || item.failure_reason != REASON_CODEGEN) begin
               nxt.reason = item.failure_reason;
               nxt.opcode = item.failing_opcode;
            end
         end
         default: begin
            we = 1'b0;
         end
      endcase
      present = addr_ok && item.command != CMD_CLEAR_ALL && (we || hit);

      upd.we       = we;
      upd.wr_entry = nxt;
      upd.rsp      = '0;
      if (present) begin
         upd.rsp.start_compile       = start;
         upd.rsp.entry_present       = 1'b1;
         upd.rsp.iteration_count     = nxt.count;
         upd.rsp.effective_threshold = nxt.threshold;
         upd.rsp.attempted_flag      = nxt.attempted;
         upd.rsp.compiled_flag       = nxt.compiled;
         upd.rsp.failed_flag         = nxt.failed;
         upd.rsp.stored_reason       = nxt.reason;
         upd.rsp.stored_opcode       = nxt.opcode;
      end
   end

endmodule

@@ design/hot_loop_osr_trigger_table_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hot_loop_osr_trigger_table_unit
// Back-edge counter table for hot-loop triggering, held in one entry RAM.
//
//   channel | ports                         | direction
//   --------+-------------------------------+----------
//   request | req_valid, req_ready, req_data| in
//   result  | rsp_valid, rsp_ready, rsp_data| out
//   csr     | csr_wr_en, csr_wr_data        | in
//
// One item per cycle while no result stall and no tag sweep hold the flow;
// the result is registered after the update stage (RAM read, then update
// and write-back with forwarding). Reset starts a tag sweep over all 8192
// entries of the RAM; every 255th clear-all repeats it. req_ready stays low
// during the sweep. A stalled result holds the one item in the update stage.
// ----------------------------------------------------------------------------
module hot_loop_osr_trigger_table_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  hlot_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output hlot_pkg::rsp_type rsp_data,
   input  logic              csr_wr_en,
   input  logic [31:0]       csr_wr_data
);
   import hlot_pkg::*;

   logic [31:0]       base_ff, base_in;

   logic              s1_valid_ff, s1_valid_in;
   req_type           s1_item_ff;
   logic [31:0]       s1_thr_ff;
   logic              s1_ok_ff;
   logic [ADDR_W-1:0] s1_addr_ff;
   logic              fwd_hit_ff;
   entry_type         fwd_data_ff;

   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff;

   logic              accept;
   logic              out_free;
   logic              s1_retire;
   logic              s1_clear;
   logic              req_ok;
   logic [ADDR_W-1:0] req_addr;
   logic [15:0]       req_span;
   logic [31:0]       req_thr;

   clr_stat_type      clr_stat;
   upd_out_type       upd;
   entry_type         stored;
   logic [ENTRY_W-1:0] ram_rd_data;
   logic               ram_wr_en;
   logic [ADDR_W-1:0]  ram_wr_addr;
   entry_type          ram_wr_entry;
   entry_type          sweep_entry;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign s1_retire = s1_valid_ff && out_free;
   assign s1_clear  = (s1_item_ff.command == CMD_CLEAR_ALL);
   assign req_ready = !clr_stat.busy &&
                      (!s1_valid_ff || (s1_retire && !(s1_clear && clr_stat.last_epoch)));
   assign accept    = req_valid && req_ready;

   assign req_ok   = (int'(req_data.program_id) < PROGRAMS) &&
                     (int'(req_data.jump_back_offset) < LOOP_OFFSETS);
   assign req_addr = ADDR_W'(int'(req_data.program_id) * LOOP_OFFSETS +
                             int'(req_data.jump_back_offset));
   assign req_span = (req_data.command == CMD_BACK_EDGE) ? req_data.loop_span : 16'd0;
   assign req_thr  = span_threshold(base_ff, req_span);

   assign base_in     = csr_wr_en ? csr_wr_data : base_ff;
   assign s1_valid_in = accept ? 1'b1 : (s1_retire ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = s1_retire ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_comb begin
      sweep_entry     = '0;
      sweep_entry.tag = TAG_NONE;
   end

   assign stored       = fwd_hit_ff ? fwd_data_ff : entry_type'(ram_rd_data);
   assign ram_wr_en    = clr_stat.busy || (s1_retire && upd.we);
   assign ram_wr_addr  = clr_stat.busy ? clr_stat.sweep_addr : s1_addr_ff;
   assign ram_wr_entry = clr_stat.busy ? sweep_entry : upd.wr_entry;

   hlot_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ENTRY_W'(ram_wr_entry)),
      .rd_en   (accept),
      .rd_addr (req_addr),
      .rd_data (ram_rd_data)
   );

   hlot_upd u_upd (
      .item      (s1_item_ff),
      .addr_ok   (s1_ok_ff),
      .first_thr (s1_thr_ff),
      .stored    (stored),
      .epoch     (clr_stat.epoch),
      .upd       (upd)
   );

   hlot_clr u_clr (
      .clock    (clock),
      .reset    (reset),
      .clear_go (s1_retire && s1_clear),
      .stat     (clr_stat)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff      <= BASE_RESET;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         fwd_hit_ff   <= 1'b0;
      end else begin
         base_ff      <= base_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            fwd_hit_ff <= s1_retire && upd.we && (s1_addr_ff == req_addr);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_item_ff  <= req_data;
         s1_thr_ff   <= req_thr;
         s1_ok_ff    <= req_ok;
         s1_addr_ff  <= req_addr;
         fwd_data_ff <= upd.wr_entry;
      end
      if (s1_retire) begin
         rsp_data_ff <= upd.rsp;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

@@ dv/tb_hot_loop_osr_trigger_table_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_hot_loop_osr_trigger_table_unit
// Self-checking bench for the hot-loop back-edge counter table. A shadow
// table works out the entry after each request transfer and every result
// transfer is compared with it field by field. A short directed run covers
// threshold discounts, mark and failure handling, unknown commands and
// clear-all. Random phases follow, each with its own base threshold and
// handshake idling, and traffic is concentrated on a few hot loops so that
// compile requests fire.
// ----------------------------------------------------------------------------
module tb_hot_loop_osr_trigger_table_unit;
   import hlot_pkg::*;

   localparam int          QUIET_LIMIT    = 30000;
   localparam int          HOT_LOOPS      = 6;
   localparam int          PHASES         = 6;
   localparam int          PHASE_ITEMS    = 267;
   localparam logic [2:0]  CMD_UNKNOWN_LO = 3'd5;
   localparam logic [2:0]  CMD_UNKNOWN_HI = 3'd7;
   localparam logic [3:0]  REASON_OTHER   = 4'd3;
   localparam logic [3:0]  REASON_TOP     = 4'd15;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_valid   = 1'b0;
   logic        req_ready;
   req_type     req_data    = '0;
   logic        rsp_valid;
   logic        rsp_ready   = 1'b0;
   rsp_type     rsp_data;
   logic        csr_wr_en   = 1'b0;
   logic [31:0] csr_wr_data = '0;

   req_type pending_reqs[$];
   rsp_type expected_entries[$];
   int      send_idle_pct  = 0;
   int      recv_stall_pct = 0;
   int      quiet_cycles   = 0;
   int      mismatches     = 0;

   // shadow of the entry table
   logic [31:0] shadow_base = BASE_RESET;
   bit          shadow_valid     [TABLE_DEPTH];
   logic [31:0] shadow_count     [TABLE_DEPTH];
   logic [31:0] shadow_thr       [TABLE_DEPTH];
   logic        shadow_attempted [TABLE_DEPTH];
   logic        shadow_compiled  [TABLE_DEPTH];
   logic        shadow_failed    [TABLE_DEPTH];
   logic [3:0]  shadow_reason    [TABLE_DEPTH];
   logic [7:0]  shadow_opcode    [TABLE_DEPTH];

   logic [2:0]  hot_prog [HOT_LOOPS];
   logic [9:0]  hot_off  [HOT_LOOPS];

   logic [31:0] phase_base [PHASES] = '{32'd4, 32'd1, 32'd9, 32'd0, 32'hFFFF_FFFF, 32'd3};
   int          phase_send [PHASES] = '{0, 68, 0, 13, 0, 13};
   int          phase_recv [PHASES] = '{0, 0, 68, 13, 0, 13};

   hot_loop_osr_trigger_table_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic logic [31:0] first_touch_threshold(input logic [31:0] base,
                                                         input logic [15:0] span);
      longint unsigned b;
      longint unsigned extra;
      longint unsigned cap;
      longint unsigned disc;
      b = 64'(base);
      if (span <= 16'd16 || base == 32'd0) begin
         return base;
      end
      cap   = b / 4;
      extra = 64'(span) - 64'd16;
      if (extra >= 64) begin
         disc = cap;
      end else begin
         disc = (extra * b) / 256;
         if (disc > cap) begin
            disc = cap;
         end
      end
      return 32'(b - disc);
   endfunction

   function automatic void open_entry(input int unsigned idx, input logic [15:0] span);
      if (!shadow_valid[idx]) begin
         shadow_valid[idx]     = 1'b1;
         shadow_count[idx]     = '0;
         shadow_thr[idx]       = first_touch_threshold(shadow_base, span);
         shadow_attempted[idx] = 1'b0;
         shadow_compiled[idx]  = 1'b0;
         shadow_failed[idx]    = 1'b0;
         shadow_reason[idx]    = REASON_NONE;
         shadow_opcode[idx]    = '0;
      end
   endfunction

   // applies one request to the shadow table and returns the entry it shows
   function automatic rsp_type entry_after_update(input req_type r);
      rsp_type     res;
      int unsigned idx;
      logic        start;
      res   = '0;
      start = 1'b0;
      if (r.command == CMD_CLEAR_ALL) begin
         shadow_valid = '{default: 1'b0};
         return res;
      end
      idx = 32'({r.program_id, r.jump_back_offset});
      case (r.command)
         CMD_BACK_EDGE: begin
            open_entry(idx, r.loop_span);
            if (!shadow_attempted[idx] && !shadow_failed[idx]) begin
               if (shadow_count[idx] != 32'hFFFF_FFFF) begin
                  shadow_count[idx] = shadow_count[idx] + 32'd1;
               end
               if (shadow_count[idx] == shadow_thr[idx]) begin
                  shadow_attempted[idx] = 1'b1;
                  start = 1'b1;
               end
            end
         end
         CMD_MARK_COMPILED: begin
            open_entry(idx, '0);
            shadow_compiled[idx] = 1'b1;
         end
         CMD_MARK_FAILED: begin
            open_entry(idx, '0);
            shadow_failed[idx] = 1'b1;
            // a codegen failure does not hide an earlier reason
            if (shadow_reason[idx] == REASON_NONE || r.failure_reason != REASON_CODEGEN) begin
               shadow_reason[idx] = r.failure_reason;
               shadow_opcode[idx] = r.failing_opcode;
            end
         end
         default: ;
      endcase
      if (shadow_valid[idx]) begin
         res.start_compile       = start;
         res.entry_present       = 1'b1;
         res.iteration_count     = shadow_count[idx];
         res.effective_threshold = shadow_thr[idx];
         res.attempted_flag      = shadow_attempted[idx];
         res.compiled_flag       = shadow_compiled[idx];
         res.failed_flag         = shadow_failed[idx];
         res.stored_reason       = shadow_reason[idx];
         res.stored_opcode       = shadow_opcode[idx];
      end
      return res;
   endfunction

   task automatic compare_field(input string field, input logic [31:0] want,
                                input logic [31:0] got);
      if (got !== want) begin
         $display("%0t %s: expected 0x%0h, actual 0x%0h", $time, field, want, got);
         mismatches++;
      end
   endtask

   task automatic compare_entry(input rsp_type want, input rsp_type got);
      compare_field("start_compile", 32'(want.start_compile), 32'(got.start_compile));
      compare_field("entry_present", 32'(want.entry_present), 32'(got.entry_present));
      compare_field("iteration_count", want.iteration_count, got.iteration_count);
      compare_field("effective_threshold", want.effective_threshold,
                    got.effective_threshold);
      compare_field("attempted_flag", 32'(want.attempted_flag), 32'(got.attempted_flag));
      compare_field("compiled_flag", 32'(want.compiled_flag), 32'(got.compiled_flag));
      compare_field("failed_flag", 32'(want.failed_flag), 32'(got.failed_flag));
      compare_field("stored_reason", 32'(want.stored_reason), 32'(got.stored_reason));
      compare_field("stored_opcode", 32'(want.stored_opcode), 32'(got.stored_opcode));
   endtask

   // request driver: prediction is taken at the request transfer
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (req_valid) begin
            expected_entries.insert(expected_entries.size(), entry_after_update(req_data));
         end
         if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            req_data  <= pending_reqs.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready    <= 1'b0;
         quiet_cycles <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_entries.size() == 0) begin
               $display("%0t result transfer with nothing expected: 0x%0h", $time, rsp_data);
               mismatches++;
            end else begin
               compare_entry(expected_entries.pop_front(), rsp_data);
            end
         end
         if ((rsp_valid && rsp_ready) || (req_valid && req_ready)) begin
            quiet_cycles <= 0;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
         rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   initial begin
      do @(negedge clock); while (quiet_cycles < QUIET_LIMIT);
      $display("TB_ERROR");
      $finish;
   end

   task automatic queue_req(input logic [2:0] cmd, input logic [2:0] prog,
                            input logic [9:0] off, input logic [15:0] span,
                            input logic [3:0] rsn, input logic [7:0] opc);
      req_type r;
      r.command          = cmd;
      r.program_id       = prog;
      r.jump_back_offset = off;
      r.loop_span        = span;
      r.failure_reason   = rsn;
      r.failing_opcode   = opc;
      pending_reqs.insert(pending_reqs.size(), r);
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (pending_reqs.size() != 0 || req_valid || expected_entries.size() != 0);
   endtask

   task automatic write_base(input logic [31:0] value);
      wait_drained();
      repeat (4) @(negedge clock);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      shadow_base = value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      @(negedge clock);
   endtask

   task automatic reshuffle_hot_loops();
      foreach (hot_prog[i]) begin
         hot_prog[i] = 3'($urandom_range(0, 7));
         hot_off[i]  = 10'($urandom_range(0, 1023));
      end
   endtask

   function automatic req_type random_req();
      req_type     r;
      int unsigned pick;
      int unsigned slot;
      pick = $urandom_range(0, 99);
      if (pick < 58) begin
         r.command = CMD_BACK_EDGE;
      end else if (pick < 68) begin
         r.command = CMD_MARK_COMPILED;
      end else if (pick < 78) begin
         r.command = CMD_MARK_FAILED;
      end else if (pick < 93) begin
         r.command = CMD_QUERY;
      end else if (pick < 95) begin
         r.command = CMD_CLEAR_ALL;
      end else begin
         r.command = 3'($urandom_range(CMD_UNKNOWN_LO, CMD_UNKNOWN_HI));
      end
      if ($urandom_range(0, 99) < 85) begin
         slot               = $urandom_range(0, HOT_LOOPS - 1);
         r.program_id       = hot_prog[slot];
         r.jump_back_offset = hot_off[slot];
      end else begin
         r.program_id       = 3'($urandom_range(0, 7));
         r.jump_back_offset = 10'($urandom_range(0, 1023));
      end
      case ($urandom_range(0, 3))
         0:       r.loop_span = 16'($urandom_range(0, 16));
         1:       r.loop_span = 16'($urandom_range(17, 80));
         2:       r.loop_span = 16'($urandom_range(81, 65535));
         default: r.loop_span = 16'($urandom);
      endcase
      if ($urandom_range(0, 3) == 0) begin
         r.failure_reason = REASON_CODEGEN;
      end else begin
         r.failure_reason = 4'($urandom_range(0, 15));
      end
      r.failing_opcode = 8'($urandom_range(0, 255));
      return r;
   endfunction

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset base threshold
      queue_req(CMD_QUERY,          3'd0, 10'd0,    16'd0,      REASON_NONE,    8'h00);
      queue_req(CMD_BACK_EDGE,      3'd7, 10'd1023, 16'hFFFF,   REASON_NONE,    8'h00);
      queue_req(CMD_BACK_EDGE,      3'd0, 10'd0,    16'd17,     REASON_NONE,    8'h00);
      queue_req(CMD_BACK_EDGE,      3'd1, 10'd5,    16'd79,     REASON_NONE,    8'h00);
      queue_req(CMD_BACK_EDGE,      3'd1, 10'd6,    16'd80,     REASON_NONE,    8'h00);
      queue_req(CMD_BACK_EDGE,      3'd1, 10'd7,    16'd16,     REASON_NONE,    8'h00);
      queue_req(CMD_MARK_COMPILED,  3'd2, 10'd7,    16'd0,      REASON_NONE,    8'h00);
      queue_req(CMD_MARK_FAILED,    3'd2, 10'd8,    16'd0,      REASON_CODEGEN, 8'hFF);
      queue_req(CMD_MARK_FAILED,    3'd2, 10'd9,    16'd0,      REASON_OTHER,   8'h12);
      queue_req(CMD_MARK_FAILED,    3'd2, 10'd9,    16'd0,      REASON_CODEGEN, 8'hAB);
      queue_req(CMD_MARK_FAILED,    3'd2, 10'd10,   16'd0,      REASON_TOP,     8'h00);
      queue_req(CMD_BACK_EDGE,      3'd2, 10'd9,    16'd0,      REASON_NONE,    8'h00);
      queue_req(CMD_UNKNOWN_LO,     3'd7, 10'd1023, 16'd0,      REASON_NONE,    8'h00);
      queue_req(CMD_UNKNOWN_LO + 3'd1, 3'd7, 10'd1023, 16'd0,   REASON_NONE,    8'h00);
      queue_req(CMD_UNKNOWN_HI,     3'd7, 10'd1023, 16'd0,      REASON_NONE,    8'h00);
      queue_req(CMD_CLEAR_ALL,      3'd0, 10'd0,    16'd0,      REASON_NONE,    8'h00);
      queue_req(CMD_QUERY,          3'd7, 10'd1023, 16'd0,      REASON_NONE,    8'h00);
      // compile request, then the attempted entry stops counting
      write_base(32'd2);
      queue_req(CMD_BACK_EDGE,      3'd3, 10'd100,  16'd0,      REASON_NONE,    8'h00);
      queue_req(CMD_BACK_EDGE,      3'd3, 10'd100,  16'd0,      REASON_NONE,    8'h00);
      queue_req(CMD_BACK_EDGE,      3'd3, 10'd100,  16'd0,      REASON_NONE,    8'h00);
      queue_req(CMD_MARK_COMPILED,  3'd3, 10'd100,  16'd0,      REASON_NONE,    8'h00);
      queue_req(CMD_MARK_FAILED,    3'd3, 10'd100,  16'd0,      REASON_NONE,    8'h55);
      write_base(32'hFFFF_FFFF);
      queue_req(CMD_BACK_EDGE,      3'd4, 10'd512,  16'hFFFF,   REASON_NONE,    8'h00);
      queue_req(CMD_BACK_EDGE,      3'd4, 10'd513,  16'd40,     REASON_NONE,    8'h00);
      write_base(32'd0);
      queue_req(CMD_BACK_EDGE,      3'd4, 10'd514,  16'd500,    REASON_NONE,    8'h00);

      for (int p = 0; p < PHASES; p++) begin
         write_base(phase_base[p]);
         send_idle_pct  = phase_send[p];
         recv_stall_pct = phase_recv[p];
         reshuffle_hot_loops();
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // sender holds off mid-phase until the table has answered everything
            if (n == PHASE_ITEMS / 2) begin
               wait_drained();
               reshuffle_hot_loops();
            end
            pending_reqs.insert(pending_reqs.size(), random_req());
         end
      end

      wait_drained();
      repeat (20) @(negedge clock);
      if (mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
